@@ rtl/pts_pkg.sv @@
// Periodic task scheduler: shared types and constants.
// Command and result words, op codes, table sizing. No dependencies.
`default_nettype none

package pts_pkg;

  localparam int PTS_NUM_SLOTS  = 16;
  // the slot field is four bits, so no more than sixteen slots can be addressed
  localparam int PTS_ADDR_SLOTS = 16;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;
  localparam logic [2:0] OP_SET_PER = 3'd5;
  localparam logic [2:0] OP_SET_LIM = 3'd6;
  localparam logic [2:0] OP_SET_IMM = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] now_ms;
    logic [31:0] period_ms;
    logic [31:0] repeat_limit;
    logic        start_enabled;
    logic        fire_at_once;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  fired_slot;
    logic [31:0] fire_number;
    logic        finished;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/periodic_task_scheduler_top.sv @@
// Tick: with scheduler_on set, busy rises after the accept edge while the table slots
// are walked in EVAL, each fire taking an extra FIRE state on the shared compare unit,
// then a FLUSH state; the next word is taken once busy falls. A tick with scheduler_on clear,
// like other ops, completes at the accept edge and busy stays low; one word a cycle while idle.
// Results are single-cycle strobes; the receiver cannot stall.
// Synchronous reset clears the whole slot table and scheduler_on at once.
`default_nettype none

module periodic_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int NUM_SLOTS = PTS_NUM_SLOTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    result_valid,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  localparam int Depth = (NUM_SLOTS < PTS_ADDR_SLOTS) ? NUM_SLOTS : PTS_ADDR_SLOTS;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EVAL  = 4'b0010,
    ST_FIRE  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t          state;
  logic [IdxW-1:0] idx;
  logic [31:0]     now_r;
  logic [31:0]     cnt1;
  logic            pend_valid;
  result_t         pend;
  logic            scheduler_on;

  logic            slot_enabled    [Depth];
  logic            slot_immediate  [Depth];
  logic [31:0]     slot_period     [Depth];
  logic [31:0]     slot_limit      [Depth];
  logic [31:0]     slot_count      [Depth];
  logic [31:0]     slot_last_start [Depth];
  logic [31:0]     orig_period     [Depth];
  logic [31:0]     orig_limit      [Depth];
  logic            orig_immediate  [Depth];

  logic [IdxW-1:0] addr;
  logic            slot_ok;
  logic [31:0]     diff;
  logic [31:0]     cmp_a;
  logic [31:0]     cmp_b;
  logic            cmp_lt;
  logic            due;
  logic            fire_done;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;
  assign addr      = busy ? idx : cmd.slot[IdxW-1:0];
  assign slot_ok   = ({28'd0, cmd.slot} < 32'(NUM_SLOTS));
  assign diff      = now_r - slot_last_start[addr];

  // shared compare unit: period < elapsed while walking, count < limit on a fire
  always_comb begin
    if (state == ST_FIRE) begin
      cmp_a = cnt1;
      cmp_b = slot_limit[addr];
    end else begin
      cmp_a = slot_period[addr];
      cmp_b = diff;
    end
    cmp_lt    = (cmp_a < cmp_b);
    due       = (slot_immediate[addr] && (slot_count[addr] == 32'd0)) || cmp_lt;
    fire_done = (slot_limit[addr] != 32'd0) && !cmp_lt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      scheduler_on <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        slot_enabled[i]    <= 1'b0;
        slot_immediate[i]  <= 1'b0;
        slot_period[i]     <= '0;
        slot_limit[i]      <= '0;
        slot_count[i]      <= '0;
        slot_last_start[i] <= '0;
        orig_period[i]     <= '0;
        orig_limit[i]      <= '0;
        orig_immediate[i]  <= 1'b0;
      end
    end else begin
      result_valid <= ((state == ST_FIRE) || (state == ST_FLUSH)) && pend_valid;
      if (cfg_valid && cfg_ready) begin
        scheduler_on <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (cmd.op == OP_TICK) begin
              if (scheduler_on) begin
                now_r <= cmd.now_ms;
                idx   <= '0;
                state <= ST_EVAL;
              end
            end else if (slot_ok) begin
              case (cmd.op)
                OP_LOAD: begin
                  slot_period[addr]     <= cmd.period_ms;
                  slot_limit[addr]      <= cmd.repeat_limit;
                  slot_immediate[addr]  <= cmd.fire_at_once;
                  slot_enabled[addr]    <= cmd.start_enabled;
                  orig_period[addr]     <= cmd.period_ms;
                  orig_limit[addr]      <= cmd.repeat_limit;
                  orig_immediate[addr]  <= cmd.fire_at_once;
                  slot_last_start[addr] <= cmd.now_ms;
                  slot_count[addr]      <= '0;
                end
                OP_ENABLE: begin
                  slot_enabled[addr]    <= 1'b1;
                  slot_last_start[addr] <= cmd.now_ms;
                end
                OP_DISABLE: begin
                  slot_enabled[addr] <= 1'b0;
                  slot_count[addr]   <= '0;
                end
                OP_RESTART: begin
                  slot_period[addr]    <= orig_period[addr];
                  slot_limit[addr]     <= orig_limit[addr];
                  slot_immediate[addr] <= orig_immediate[addr];
                  slot_enabled[addr]   <= 1'b0;
                  slot_count[addr]     <= '0;
                end
                OP_SET_PER: slot_period[addr]    <= cmd.period_ms;
                OP_SET_LIM: slot_limit[addr]     <= cmd.repeat_limit;
                OP_SET_IMM: slot_immediate[addr] <= cmd.fire_at_once;
                default: ;
              endcase
            end
          end
        end
        ST_EVAL: begin
          if (slot_enabled[addr] && due) begin
            cnt1  <= slot_count[addr] + 32'd1;
            state <= ST_FIRE;
          end else if (idx == LastIdx) begin
            state <= ST_FLUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_FIRE: begin
          slot_immediate[addr] <= 1'b0;
          if (fire_done) begin
            slot_enabled[addr] <= 1'b0;
            slot_count[addr]   <= '0;
          end else begin
            slot_count[addr]      <= cnt1;
            slot_last_start[addr] <= now_r;
          end
          // hold each result back one fire so the final one can carry last
          if (pend_valid) begin
            result <= pend;
          end
          pend.fired_slot  <= 4'(idx);
          pend.fire_number <= cnt1;
          pend.finished    <= fire_done;
          pend.last        <= 1'b0;
          pend_valid       <= 1'b1;
          if (idx == LastIdx) begin
            state <= ST_FLUSH;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_EVAL;
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            result     <= {pend.fired_slot, pend.fire_number, pend.finished, 1'b1};
            pend_valid <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/pts_checker.sv @@
// Port-level checks for the periodic task scheduler, bound to the top level.
// Depends on pts_pkg for the command and result word types.
`default_nettype none

module pts_checker
  import pts_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire cmd_t    cmd,
  input wire logic    result_valid,
  input wire result_t result,
  input wire logic    cfg_valid,
  input wire logic    cfg_ready
);

  // non-tick ops finish at the accept edge
  a_op_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.op != OP_TICK)) |=> !busy)
    else $error("busy after non-tick op");

  // more results follow a word without last, so the walk is still running
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("result without last outside a tick");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result straight after last");

  a_tick_start_clean: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !result_valid)
    else $error("stale result as tick begins");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !busy)
    else $error("config taken while busy");

endmodule

bind periodic_task_scheduler_top pts_checker u_pts_checker (.*);

`default_nettype wire
